[design/dsa_pkg.sv]
// ----------------------------------------------------------------------------
// Descriptor slot allocator package
// Shared sizes, operation and status codes, and the controller command type.
// ----------------------------------------------------------------------------
package dsa_pkg;

    // Table geometry.
    localparam int SLOT_COUNT       = 64;
    localparam int SLOT_W           = $clog2(SLOT_COUNT);
    localparam int FIRST_ALLOC_SLOT = 3;

    // Field widths.
    localparam int OP_W     = 2;
    localparam int FD_W     = 8;
    localparam int FD_OUT_W = 7;
    localparam int HANDLE_W = 32;
    localparam int STATUS_W = 2;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // latch the request and read its slot
        logic execute;  // update the table and load the result register
    } t_dsa_cmd;

endpackage

[design/dsa_ctrl.sv]
// ----------------------------------------------------------------------------
// Descriptor slot allocator controller
// Sequences each request through capture and execute and owns both handshakes.
// ----------------------------------------------------------------------------
module dsa_ctrl
    import dsa_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_dsa_cmd o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   out_free;

    // The result register can take a new value when empty or when being drained.
    assign out_free      = !r_out_valid || !i_out_stall;
    assign o_cmd.capture = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.execute = (r_state == S_EXEC) && out_free;
    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;

    // State and the output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (o_cmd.execute) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

[design/dsa_dp.sv]
// ----------------------------------------------------------------------------
// Descriptor slot allocator datapath
// Handle memory, occupancy bitmap, lowest-free-slot search and result register.
// ----------------------------------------------------------------------------
module dsa_dp
    import dsa_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_dsa_cmd                   i_cmd,
    input  logic [OP_W-1:0]            i_op,
    input  logic signed [FD_W-1:0]     i_fd,
    input  logic [HANDLE_W-1:0]        i_handle,
    output logic [STATUS_W-1:0]        o_status,
    output logic [FD_OUT_W-1:0]        o_fd_out,
    output logic [HANDLE_W-1:0]        o_handle_out
);

    // Handle storage; an entry is meaningful only while its used bit is set.
    logic [HANDLE_W-1:0]   r_mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_used;

    // Captured request and the handle read for it.
    logic [OP_W-1:0]       r_op;
    logic [FD_W-1:0]       r_fd;
    logic [HANDLE_W-1:0]   r_handle;
    logic [HANDLE_W-1:0]   r_rd_data;

    // Result register.
    logic [STATUS_W-1:0]   r_status;
    logic [FD_OUT_W-1:0]   r_fd_out;
    logic [HANDLE_W-1:0]   r_handle_out;

    logic                  fd_ok;
    logic [SLOT_W-1:0]     fd_slot;
    logic                  alloc_found;
    logic [SLOT_W-1:0]     alloc_slot;
    logic [STATUS_W-1:0]   n_status;
    logic [FD_OUT_W-1:0]   n_fd_out;
    logic [HANDLE_W-1:0]   n_handle_out;

    // A descriptor is valid when it is non-negative and below the slot count.
    assign fd_ok   = !r_fd[FD_W-1] && (r_fd[FD_W-2:0] < FD_OUT_W'(SLOT_COUNT));
    assign fd_slot = r_fd[SLOT_W-1:0];

    // Priority encoder: lowest free slot at or above the first allocatable one.
    always_comb begin
        alloc_found = 1'b0;
        alloc_slot  = '0;
        for (int i = SLOT_COUNT - 1; i >= FIRST_ALLOC_SLOT; i--) begin
            if (!r_used[i]) begin
                alloc_found = 1'b1;
                alloc_slot  = SLOT_W'(i);
            end
        end
    end

    // Result of the captured request.
    always_comb begin
        n_status     = ST_OK;
        n_fd_out     = '0;
        n_handle_out = '0;
        case (r_op)
            OP_ALLOC: begin
                if (alloc_found) begin
                    n_fd_out = FD_OUT_W'(alloc_slot);
                end else begin
                    n_status = ST_FULL;
                end
            end
            OP_FREE: begin
                if (!fd_ok) begin
                    n_status = ST_RANGE;
                end
            end
            OP_READ: begin
                if (!fd_ok) begin
                    n_status = ST_RANGE;
                end else if (r_used[fd_slot]) begin
                    n_handle_out = r_rd_data;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // Request capture and memory access.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op      <= i_op;
            r_fd      <= i_fd;
            r_handle  <= i_handle;
            r_rd_data <= r_mem[i_fd[SLOT_W-1:0]];
        end
        if (i_cmd.execute && (r_op == OP_ALLOC) && alloc_found) begin
            r_mem[alloc_slot] <= r_handle;
        end
    end

    // Occupancy bitmap; a zero handle leaves its slot free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_cmd.execute) begin
            if ((r_op == OP_ALLOC) && alloc_found) begin
                r_used[alloc_slot] <= (r_handle != '0);
            end else if ((r_op == OP_FREE) && fd_ok) begin
                r_used[fd_slot] <= 1'b0;
            end
        end
    end

    // Result register, loaded once per request.
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_status     <= n_status;
            r_fd_out     <= n_fd_out;
            r_handle_out <= n_handle_out;
        end
    end

    assign o_status     = r_status;
    assign o_fd_out     = r_fd_out;
    assign o_handle_out = r_handle_out;

endmodule

[design/descriptor_slot_allocator_top.sv]
// ----------------------------------------------------------------------------
// Descriptor slot allocator
// Table of 32-bit handles: allocate the lowest free slot, free or read a slot.
//
// Channel   Direction  Handshake                  Fields
// request   in         i_in_valid / o_in_stall    i_op, i_fd, i_handle
// result    out        o_out_valid / i_out_stall  o_status, o_fd_out, o_handle_out
//
// Each request is first captured, which also reads its slot from the handle
// memory; execute then searches the free bitmap, updates the table and loads the
// result register. A request can be taken while the previous result waits; the
// execute step waits until the result register is empty or being drained.
// Synchronous reset clears the occupancy bitmap, so every slot reads as free.
// ----------------------------------------------------------------------------
module descriptor_slot_allocator_top
    import dsa_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [OP_W-1:0]        i_op,
    input  logic signed [FD_W-1:0] i_fd,
    input  logic [HANDLE_W-1:0]    i_handle,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [STATUS_W-1:0]    o_status,
    output logic [FD_OUT_W-1:0]    o_fd_out,
    output logic [HANDLE_W-1:0]    o_handle_out
);

    t_dsa_cmd cmd;

    // Controller: handshakes and sequencing.
    dsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    // Datapath: table storage and result computation.
    dsa_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_op         (i_op),
        .i_fd         (i_fd),
        .i_handle     (i_handle),
        .o_status     (o_status),
        .o_fd_out     (o_fd_out),
        .o_handle_out (o_handle_out)
    );

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// Descriptor slot allocator testbench
// Sends allocate, free and read requests through the request channel and
// checks every response against a local model of the descriptor table.
// Both sides insert random gaps. The receiver also holds off twice for a long
// stretch, and the sender pauses at the start of every fourth phase until all
// responses have been checked.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import dsa_pkg::*;

    // Opcode that the block leaves unused. It still returns an all-zero response.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int RESET_CYCLES  = 12;
    localparam int PHASE_COUNT   = 16;
    localparam int PHASE_ITEMS   = 100;
    localparam int LONG_HOLD     = 300;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 16;

    typedef enum int {MIX_FILL, MIX_MIXED, MIX_DRAIN} t_op_mix;

    typedef struct {
        logic [OP_W-1:0]        op;
        logic signed [FD_W-1:0] fd;
        logic [HANDLE_W-1:0]    handle;
        bit                     wait_idle;  // hold this request until all responses are back
    } t_slot_request;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [FD_OUT_W-1:0] fd_out;
        logic [HANDLE_W-1:0] handle_out;
    } t_slot_response;

    logic                   i_clk        = 1'b0;
    logic                   i_rst_n      = 1'b0;
    logic                   i_in_valid   = 1'b0;
    logic                   o_in_stall;
    logic [OP_W-1:0]        i_op         = '0;
    logic signed [FD_W-1:0] i_fd         = '0;
    logic [HANDLE_W-1:0]    i_handle     = '0;
    logic                   o_out_valid;
    logic                   i_out_stall  = 1'b0;
    logic [STATUS_W-1:0]    o_status;
    logic [FD_OUT_W-1:0]    o_fd_out;
    logic [HANDLE_W-1:0]    o_handle_out;

    t_slot_request  request_queue[$];
    t_slot_response expected_responses[$];
    logic [HANDLE_W-1:0] handle_table [SLOT_COUNT];

    int mismatch_count = 0;
    int checked_count  = 0;
    int alloc_count    = 0;
    int full_count     = 0;
    int free_count     = 0;
    int read_count     = 0;
    int range_count    = 0;
    int unused_count   = 0;
    int idle_cycles    = 0;

    descriptor_slot_allocator_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_fd         (i_fd),
        .i_handle     (i_handle),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_fd_out     (o_fd_out),
        .o_handle_out (o_handle_out)
    );

    always #2 i_clk = ~i_clk;

    // Apply one request to the local descriptor table and return its response.
    function automatic t_slot_response table_response(input t_slot_request req);
        t_slot_response rsp;
        int             slot;
        rsp.status     = ST_OK;
        rsp.fd_out     = '0;
        rsp.handle_out = '0;
        slot           = req.fd;
        case (req.op)
            OP_ALLOC: begin
                alloc_count++;
                rsp.status = ST_FULL;
                for (int s = FIRST_ALLOC_SLOT; s < SLOT_COUNT; s++) begin
                    if (handle_table[s] == '0) begin
                        handle_table[s] = req.handle;
                        rsp.fd_out      = FD_OUT_W'(s);
                        rsp.status      = ST_OK;
                        break;
                    end
                end
                if (rsp.status == ST_FULL) begin
                    full_count++;
                end
            end
            OP_FREE, OP_READ: begin
                if (req.op == OP_FREE) begin
                    free_count++;
                end else begin
                    read_count++;
                end
                if (slot < 0 || slot >= SLOT_COUNT) begin
                    rsp.status = ST_RANGE;
                    range_count++;
                end else if (req.op == OP_FREE) begin
                    handle_table[slot] = '0;
                end else begin
                    rsp.handle_out = handle_table[slot];
                end
            end
            default: begin
                unused_count++;
            end
        endcase
        return rsp;
    endfunction

    // Mostly short gaps, a few long ones, and none at all while gaps are off.
    function automatic int pick_gap(input bit gaps_on);
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Request driver: presents the next queued request and predicts its response
    // when the transfer happens.
    int sender_gap     = 0;
    bit sender_gaps_on = 1'b1;

    always @(posedge i_clk) begin
        t_slot_request req;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                req.op        = i_op;
                req.fd        = i_fd;
                req.handle    = i_handle;
                req.wait_idle = 1'b0;
                expected_responses.push_back(table_response(req));
            end
            if ($urandom_range(0, 149) == 0) begin
                sender_gaps_on = ~sender_gaps_on;
            end
            // A stalled transfer keeps its payload; otherwise decide the next cycle.
            if (!(i_in_valid && o_in_stall)) begin
                if (sender_gap > 0) begin
                    sender_gap--;
                    i_in_valid <= 1'b0;
                end else if (request_queue.size() > 0 &&
                             !(request_queue[0].wait_idle &&
                               expected_responses.size() > 0)) begin
                    req = request_queue.pop_front();
                    i_in_valid <= 1'b1;
                    i_op       <= req.op;
                    i_fd       <= req.fd;
                    i_handle   <= req.handle;
                    sender_gap = pick_gap(sender_gaps_on);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor: checks each transfer against the oldest prediction and
    // drives the receiver's stall pattern.
    int receiver_hold     = 0;
    bit receiver_gaps_on  = 1'b1;
    bit first_hold_done   = 1'b0;
    bit second_hold_done  = 1'b0;

    always @(posedge i_clk) begin
        t_slot_response exp_rsp;
        int             hold_len;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                checked_count++;
                if (expected_responses.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: response with nothing expected: status %0d fd_out %0d",
                             $time, o_status, o_fd_out);
                    $display("%0t: unexpected handle_out %h", $time, o_handle_out);
                end else begin
                    exp_rsp = expected_responses.pop_front();
                    if (o_status !== exp_rsp.status) begin
                        mismatch_count++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_rsp.status, o_status);
                    end
                    if (o_fd_out !== exp_rsp.fd_out) begin
                        mismatch_count++;
                        $display("%0t: fd_out expected %0d actual %0d",
                                 $time, exp_rsp.fd_out, o_fd_out);
                    end
                    if (o_handle_out !== exp_rsp.handle_out) begin
                        mismatch_count++;
                        $display("%0t: handle_out expected %h actual %h",
                                 $time, exp_rsp.handle_out, o_handle_out);
                    end
                end
            end
            if ($urandom_range(0, 149) == 0) begin
                receiver_gaps_on = ~receiver_gaps_on;
            end
            // Two long hold-offs let the block fill up and stall the sender.
            if (!first_hold_done && checked_count >= 400) begin
                first_hold_done = 1'b1;
                receiver_hold   = LONG_HOLD;
            end else if (!second_hold_done && checked_count >= 1200) begin
                second_hold_done = 1'b1;
                receiver_hold    = LONG_HOLD;
            end
            if (receiver_hold > 0) begin
                receiver_hold--;
                i_out_stall <= 1'b1;
            end else begin
                hold_len = pick_gap(receiver_gaps_on);
                if (hold_len > 0) begin
                    receiver_hold = hold_len - 1;
                    i_out_stall <= 1'b1;
                end else begin
                    i_out_stall <= 1'b0;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer on either channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic queue_request(input logic [OP_W-1:0] op, input logic signed [FD_W-1:0] fd,
                                 input logic [HANDLE_W-1:0] handle, input bit wait_idle);
        t_slot_request req;
        req.op        = op;
        req.fd        = fd;
        req.handle    = handle;
        req.wait_idle = wait_idle;
        request_queue.push_back(req);
    endtask

    // Random request whose operation mix depends on the phase.
    task automatic queue_random(input t_op_mix mix, input bit wait_idle);
        int                     r;
        logic [OP_W-1:0]        op;
        logic signed [FD_W-1:0] fd;
        logic [HANDLE_W-1:0]    handle;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:  op = (r < 75) ? OP_ALLOC : (r < 88) ? OP_FREE : OP_READ;
            MIX_DRAIN: op = (r < 20) ? OP_ALLOC : (r < 75) ? OP_FREE : OP_READ;
            default:   op = (r < 40) ? OP_ALLOC : (r < 65) ? OP_FREE : OP_READ;
        endcase
        if ($urandom_range(0, 99) == 0) begin
            op = OP_UNUSED;
        end
        // Descriptors: reserved slots, any in-range slot, or out of range either way.
        r = $urandom_range(0, 99);
        if (r < 10) begin
            fd = FD_W'($urandom_range(0, FIRST_ALLOC_SLOT - 1));
        end else if (r < 85) begin
            fd = FD_W'($urandom_range(0, SLOT_COUNT - 1));
        end else begin
            fd = FD_W'($urandom_range(SLOT_COUNT, 255));
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            handle = '0;
        end else if (r < 6) begin
            handle = '1;
        end else begin
            handle = $urandom;
        end
        queue_request(op, fd, handle, wait_idle);
    endtask

    initial begin
        // Directed requests: field extremes, reserved slots, zero handle, bad descriptors.
        queue_request(OP_READ,   8'sd0,    32'h1234_5678, 1'b0);
        queue_request(OP_ALLOC,  -8'sd128, 32'hFFFF_FFFF, 1'b0);
        queue_request(OP_ALLOC,  8'sd127,  32'h0000_0000, 1'b0);
        queue_request(OP_ALLOC,  8'sd0,    32'h0000_0001, 1'b0);
        queue_request(OP_READ,   8'sd3,    32'h0000_0000, 1'b0);
        queue_request(OP_READ,   8'sd4,    32'hFFFF_FFFF, 1'b0);
        queue_request(OP_READ,   8'sd5,    32'h0000_0000, 1'b0);
        queue_request(OP_READ,   8'sd63,   32'h0000_0000, 1'b0);
        queue_request(OP_READ,   8'sd64,   32'h0000_0000, 1'b0);
        queue_request(OP_READ,   8'sd127,  32'h0000_0000, 1'b0);
        queue_request(OP_READ,   -8'sd1,   32'h0000_0000, 1'b0);
        queue_request(OP_READ,   -8'sd128, 32'h0000_0000, 1'b0);
        queue_request(OP_FREE,   -8'sd128, 32'h0000_0000, 1'b0);
        queue_request(OP_FREE,   8'sd64,   32'h0000_0000, 1'b0);
        queue_request(OP_FREE,   -8'sd1,   32'hFFFF_FFFF, 1'b0);
        queue_request(OP_FREE,   8'sd0,    32'h0000_0000, 1'b0);
        queue_request(OP_FREE,   8'sd3,    32'h0000_0000, 1'b0);
        queue_request(OP_READ,   8'sd3,    32'h0000_0000, 1'b0);
        queue_request(OP_ALLOC,  8'sd0,    32'h8000_0000, 1'b0);
        queue_request(OP_READ,   8'sd3,    32'h0000_0000, 1'b0);
        queue_request(OP_UNUSED, 8'sd5,    32'hAAAA_5555, 1'b0);
        queue_request(OP_FREE,   8'sd63,   32'h0000_0000, 1'b0);
        queue_request(OP_READ,   8'sd4,    32'h0000_0000, 1'b0);

        // Random phases that cycle through a filling, a mixed and a draining operation mix.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                queue_random(t_op_mix'(p % 3), (n == 0) && (p % 4 == 1));
            end
        end

        for (int s = 0; s < SLOT_COUNT; s++) begin
            handle_table[s] = '0;
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Let every request go through, then drain the responses.
        while (request_queue.size() > 0 || i_in_valid) begin
            @(posedge i_clk);
        end
        while (expected_responses.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Checked %0d responses: %0d allocates (%0d with the table full), %0d frees,",
                 checked_count, alloc_count, full_count, free_count);
        $display("%0d reads, %0d out-of-range descriptors, %0d unused opcodes.",
                 read_count, range_count, unused_count);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[sim.f]
design/dsa_pkg.sv
design/dsa_ctrl.sv
design/dsa_dp.sv
design/descriptor_slot_allocator_top.sv
tb/testbench.sv
